>>> sv/grmd_pkg.sv
// ----------------------------------------------------------------------------
// grmd_pkg: shared types and constants for the grid ray march block
// Grid geometry, step limit, sequencer states and the step-unit interface.
// ----------------------------------------------------------------------------
package grmd_pkg;

    localparam int GRID_SIDE   = 16;
    localparam int MAX_STEPS   = 48;
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);
    // Map coordinates stay within start cell +/- MAX_STEPS.
    localparam int MAP_W       = 10;
    // Boundary distance: up to 256 + 256 * MAX_STEPS.
    localparam int BND_W       = 17;
    localparam int ABS_W       = 17;
    localparam int PROD_W      = BND_W + ABS_W;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_DONE
    } state_t;

    // Ray setup as seen by the step unit.
    typedef struct packed {
        logic satx;
        logic saty;
        logic negx;
        logic negy;
        logic [ABS_W-1:0] adx;
        logic [ABS_W-1:0] ady;
    } ray_dir_t;

endpackage

>>> sv/grmd_ram.sv
// ----------------------------------------------------------------------------
// grmd_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module grmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

>>> sv/grmd_step.sv
// ----------------------------------------------------------------------------
// grmd_step: shared DDA step unit
// One multiplier is used twice per step to form bx*|dy| and by*|dx|;
// the compare of the two products picks the axis or axes that step.
// ----------------------------------------------------------------------------
module grmd_step (
    input  logic                           aclk,
    input  logic                           sel_y,
    input  grmd_pkg::ray_dir_t             dir,
    input  logic [grmd_pkg::BND_W-1:0]     bx,
    input  logic [grmd_pkg::BND_W-1:0]     by,
    input  logic                           cap_x,
    output logic                           stepx,
    output logic                           stepy
);

    logic [grmd_pkg::BND_W-1:0]  mul_a;
    logic [grmd_pkg::ABS_W-1:0]  mul_b;
    logic [grmd_pkg::PROD_W-1:0] prod;
    logic [grmd_pkg::PROD_W-1:0] lx_reg;

    assign mul_a = sel_y ? by : bx;
    assign mul_b = sel_y ? dir.adx : dir.ady;
    assign prod  = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cap_x) begin
            lx_reg <= prod;
        end
    end

    // Evaluated in the cycle in which prod holds by*|dx|.
    always_comb begin
        if (dir.satx && dir.saty) begin
            stepx = 1'b1;
            stepy = 1'b1;
        end else if (dir.satx) begin
            stepx = 1'b0;
            stepy = 1'b1;
        end else if (dir.saty) begin
            stepx = 1'b1;
            stepy = 1'b0;
        end else begin
            stepx = (lx_reg <= prod);
            stepy = (prod <= lx_reg);
        end
    end

endmodule

>>> sv/grid_ray_march_dda.sv
// ----------------------------------------------------------------------------
// grid_ray_march_dda: 2D DDA ray march through a 16x16 occupancy grid
//
// One input stream (s_axis_*) carries write words and ray words, selected by
// s_axis_tuser (0 writes a cell, 1 fires a ray). Every input word produces
// exactly one result word on m_axis_*. A write stores cell_value at
// cell_index and returns an all-zero acknowledgement.
// A ray marches from the cell holding the start point along eye-to-start,
// visiting up to 48 cells; each visit passes through a RAM read state, a
// check state and, unless the march ends there, a multiply state (the single
// shared multiplier forms both cross products).
// The block accepts one word at a time; s_axis_tready is low while a word
// is in progress or its result waits. A stalled m_axis_tready holds the
// result word stable in its output register.
// Reset clears the grid with a pass over all 256 cells (one cell per cycle),
// during which no word is accepted.
// ----------------------------------------------------------------------------
module grid_ray_march_dda (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cell_index[7:0], cell_value[15:8], eye_x[31:16], eye_y[47:32],
    //        start_x[63:48], start_y[79:64]
    input  logic [79:0] s_axis_tdata,
    // tuser: func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: hit[0], hit_value[8:1], hit_x[12:9], hit_y[16:13], zeros above
    output logic [23:0] m_axis_tdata
);

    localparam int MW = grmd_pkg::MAP_W;
    localparam int BW = grmd_pkg::BND_W;

    grmd_pkg::state_t state_reg, state_next;

    logic                        clr_reg;
    logic [grmd_pkg::ADDR_W:0]   clr_cnt_reg;
    grmd_pkg::ray_dir_t          dir_reg;
    logic signed [MW-1:0]        mx_reg, my_reg;
    logic [BW-1:0]               bx_reg, by_reg;
    logic [grmd_pkg::STEP_W-1:0] cnt_reg;
    logic                        in_grid_reg;
    logic                        out_valid_reg;
    logic [16:0]                 out_data_reg;

    logic                        accept;
    logic                        ram_we;
    logic [grmd_pkg::ADDR_W-1:0] ram_addr;
    logic [7:0]                  ram_wdata, ram_rdata;
    logic                        stepx, stepy;
    logic                        in_grid;
    logic                        found, last;

    logic signed [16:0] dx, dy;
    logic [7:0]         fx, fy;

    assign s_axis_tready = !clr_reg && state_reg == grmd_pkg::ST_IDLE && !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign dx = 17'(signed'(s_axis_tdata[63:48])) - 17'(signed'(s_axis_tdata[31:16]));
    assign dy = 17'(signed'(s_axis_tdata[79:64])) - 17'(signed'(s_axis_tdata[47:32]));
    assign fx = s_axis_tdata[55:48];
    assign fy = s_axis_tdata[71:64];

    assign in_grid = mx_reg >= 0 && mx_reg < MW'(grmd_pkg::GRID_SIDE)
                  && my_reg >= 0 && my_reg < MW'(grmd_pkg::GRID_SIDE);

    // RAM port: clearing, write words, or the current cell read.
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = s_axis_tdata[15:8];
        ram_addr  = 8'(my_reg * MW'(grmd_pkg::GRID_SIDE) + mx_reg);
        if (clr_reg) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            ram_addr  = clr_cnt_reg[grmd_pkg::ADDR_W-1:0];
        end else if (accept && s_axis_tuser == grmd_pkg::FUNC_WRITE) begin
            ram_we   = 1'b1;
            ram_addr = s_axis_tdata[7:0];
        end
    end

    grmd_ram #(.WIDTH(8), .DEPTH(grmd_pkg::STORE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    grmd_step u_step (
        .aclk  (aclk),
        .sel_y (state_reg == grmd_pkg::ST_MUL),
        .dir   (dir_reg),
        .bx    (bx_reg),
        .by    (by_reg),
        .cap_x (state_reg == grmd_pkg::ST_CHECK),
        .stepx (stepx),
        .stepy (stepy)
    );

    assign found = in_grid_reg && ram_rdata != 8'd0;
    assign last  = cnt_reg == grmd_pkg::STEP_W'(grmd_pkg::MAX_STEPS - 1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            grmd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_axis_tuser == grmd_pkg::FUNC_RAY) ?
                                 grmd_pkg::ST_READ : grmd_pkg::ST_DONE;
                end
            end
            grmd_pkg::ST_READ:  state_next = grmd_pkg::ST_CHECK;
            grmd_pkg::ST_CHECK: state_next = (found || last) ? grmd_pkg::ST_DONE
                                                             : grmd_pkg::ST_MUL;
            grmd_pkg::ST_MUL:   state_next = grmd_pkg::ST_READ;
            grmd_pkg::ST_DONE:  state_next = grmd_pkg::ST_IDLE;
            default:            state_next = grmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= grmd_pkg::ST_IDLE;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + (grmd_pkg::ADDR_W+1)'(1);
                if (clr_cnt_reg == (grmd_pkg::ADDR_W+1)'(grmd_pkg::STORE_DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (state_reg == grmd_pkg::ST_DONE) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ray datapath.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg  <= '0;
            cnt_reg       <= '0;
            dir_reg.satx  <= dx == 0;
            dir_reg.saty  <= dy == 0;
            dir_reg.negx  <= dx < 0;
            dir_reg.negy  <= dy < 0;
            dir_reg.adx   <= dx < 0 ? 17'(-dx) : 17'(dx);
            dir_reg.ady   <= dy < 0 ? 17'(-dy) : 17'(dy);
            mx_reg        <= MW'(signed'(s_axis_tdata[63:56]));
            my_reg        <= MW'(signed'(s_axis_tdata[79:72]));
            bx_reg        <= dx > 0 ? BW'(9'd256 - 9'(fx)) : (dx < 0 ? BW'(fx) : '0);
            by_reg        <= dy > 0 ? BW'(9'd256 - 9'(fy)) : (dy < 0 ? BW'(fy) : '0);
        end
        if (state_reg == grmd_pkg::ST_READ) begin
            in_grid_reg <= in_grid;
        end
        if (state_reg == grmd_pkg::ST_CHECK && found) begin
            out_data_reg <= {my_reg[3:0], mx_reg[3:0], ram_rdata, 1'b1};
        end
        if (state_reg == grmd_pkg::ST_MUL) begin
            cnt_reg <= cnt_reg + grmd_pkg::STEP_W'(1);
            if (stepx) begin
                bx_reg <= bx_reg + BW'(256);
                if (!dir_reg.satx) begin
                    mx_reg <= dir_reg.negx ? mx_reg - MW'(1) : mx_reg + MW'(1);
                end
            end
            if (stepy) begin
                by_reg <= by_reg + BW'(256);
                if (!dir_reg.saty) begin
                    my_reg <= dir_reg.negy ? my_reg - MW'(1) : my_reg + MW'(1);
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};

    property p_no_accept_in_clear;
        @(posedge aclk) disable iff (!aresetn) clr_reg |-> !s_axis_tready;
    endproperty
    a_no_accept_in_clear: assert property (p_no_accept_in_clear)
        else $error("word accepted during grid clear");

    property p_done_gives_valid;
        @(posedge aclk) disable iff (!aresetn)
            state_reg == grmd_pkg::ST_DONE |=> m_axis_tvalid;
    endproperty
    a_done_gives_valid: assert property (p_done_gives_valid)
        else $error("finished word did not reach output");

    property p_step_bound;
        @(posedge aclk) disable iff (!aresetn)
            state_reg == grmd_pkg::ST_CHECK |->
            cnt_reg < grmd_pkg::STEP_W'(grmd_pkg::MAX_STEPS);
    endproperty
    a_step_bound: assert property (p_step_bound)
        else $error("step count past limit");

endmodule
